[design/mpq_pkg.sv]
package mpq_pkg;

  typedef enum logic [1:0] {
    CMD_ADD      = 2'd0,
    CMD_REMOVE   = 2'd1,
    CMD_SCHEDULE = 2'd2,
    CMD_YIELD    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_DONE    = 2'd0,
    STATUS_IGNORED = 2'd1,
    STATUS_NONE    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_PICK,
    ST_READ,
    ST_UNLINK,
    ST_RESP
  } state_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [5:0] thread_id;
    logic [4:0] priority_req;
    logic       quantum_expired;
  } in_t;

  typedef struct packed {
    status_t    status;
    logic [5:0] current_thread;
    logic       current_valid;
  } out_t;

endpackage

[design/mpq_ram.sv]
module mpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/mpq_level_pick.sv]
module mpq_level_pick #(
  parameter int LEVELS = 31
) (
  input  logic [LEVELS-1:0]         nonempty,
  output logic                      found,
  output logic [$clog2(LEVELS)-1:0] level
);

  logic [LEVELS-1:0] first;

  assign first = nonempty & (~nonempty + LEVELS'(1));
  assign found = |nonempty;

  always_comb begin
    level = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (first[i]) begin
        level = level | ($clog2(LEVELS))'(i);
      end
    end
  end

endmodule

[design/multilevel_priority_ready_queue.sv]
// After DECODE, add goes to RESP; remove to READ, UNLINK, RESP (or RESP for a bad
// or unqueued slot); schedule and yield to PICK, READ, UNLINK, RESP (or PICK, RESP
// with no ready thread). One transaction is in work at a time; the next input is
// taken in the cycle after the result is accepted. READ waits for the registered
// link reads. Synchronous reset empties every queue and clears the current thread.
module multilevel_priority_ready_queue #(
  parameter int LEVELS       = 31,
  parameter int THREAD_SLOTS = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  mpq_pkg::in_t in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output mpq_pkg::out_t out_data
);

  localparam int SW = $clog2(THREAD_SLOTS);
  localparam int LW = $clog2(LEVELS);

  mpq_pkg::state_t  state, state_next;
  mpq_pkg::in_t     req;
  mpq_pkg::status_t status;

  logic [SW-1:0]           target;
  logic [LW-1:0]           target_lv;
  logic                    is_sched;
  logic [SW-1:0]           head [LEVELS];
  logic [SW-1:0]           tail [LEVELS];
  logic [LEVELS-1:0]       nonempty;
  logic [THREAD_SLOTS-1:0] queued;
  logic [SW-1:0]           running_slot;
  logic [LW-1:0]           running_level;
  logic                    running_valid;

  logic [SW-1:0] next_rd, prev_rd;
  logic [LW-1:0] lvl_rd;

  logic [SW-1:0] req_slot;
  logic [LW-1:0] req_lv;
  logic          req_bad;
  logic          pick_found;
  logic [LW-1:0] pick_lv;

  logic          push_en;
  logic [SW-1:0] push_slot;
  logic [LW-1:0] push_lv;
  logic          unlink_en;
  logic          is_head, is_tail;

  logic          next_we, prev_we;
  logic [SW-1:0] next_waddr, next_wdata, prev_waddr, prev_wdata;

  assign req_slot = SW'(req.thread_id);
  assign req_lv   = LW'(req.priority_req - 5'd1);
  assign req_bad  = (int'(req.thread_id) >= THREAD_SLOTS) || (req.priority_req == 5'd0) ||
                    (int'(req.priority_req) > LEVELS);

  assign is_head = head[target_lv] == target;
  assign is_tail = tail[target_lv] == target;

  mpq_level_pick #(.LEVELS(LEVELS)) u_pick (
    .nonempty(nonempty),
    .found   (pick_found),
    .level   (pick_lv)
  );

  mpq_ram #(.WIDTH(SW), .DEPTH(THREAD_SLOTS)) u_next_ram (
    .clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
    .raddr(target), .rdata(next_rd)
  );

  mpq_ram #(.WIDTH(SW), .DEPTH(THREAD_SLOTS)) u_prev_ram (
    .clk(clk), .we(prev_we), .waddr(prev_waddr), .wdata(prev_wdata),
    .raddr(target), .rdata(prev_rd)
  );

  mpq_ram #(.WIDTH(LW), .DEPTH(THREAD_SLOTS)) u_level_ram (
    .clk(clk), .we(push_en), .waddr(push_slot), .wdata(push_lv),
    .raddr(target), .rdata(lvl_rd)
  );

  always_comb begin
    state_next = state;
    case (state)
      mpq_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = mpq_pkg::ST_DECODE;
        end
      end
      mpq_pkg::ST_DECODE: begin
        case (req.cmd)
          mpq_pkg::CMD_ADD: state_next = mpq_pkg::ST_RESP;
          mpq_pkg::CMD_REMOVE: begin
            if (req_bad || !queued[req_slot]) begin
              state_next = mpq_pkg::ST_RESP;
            end else begin
              state_next = mpq_pkg::ST_READ;
            end
          end
          default: state_next = mpq_pkg::ST_PICK;
        endcase
      end
      mpq_pkg::ST_PICK: begin
        state_next = pick_found ? mpq_pkg::ST_READ : mpq_pkg::ST_RESP;
      end
      mpq_pkg::ST_READ:   state_next = mpq_pkg::ST_UNLINK;
      mpq_pkg::ST_UNLINK: state_next = mpq_pkg::ST_RESP;
      mpq_pkg::ST_RESP: begin
        if (out_ready) begin
          state_next = mpq_pkg::ST_IDLE;
        end
      end
      default: state_next = mpq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = state == mpq_pkg::ST_IDLE;
    out_valid  = state == mpq_pkg::ST_RESP;
    push_en    = 1'b0;
    push_slot  = req_slot;
    push_lv    = req_lv;
    unlink_en  = 1'b0;
    next_we    = 1'b0;
    next_waddr = tail[push_lv];
    next_wdata = push_slot;
    prev_we    = 1'b0;
    prev_waddr = push_slot;
    prev_wdata = tail[push_lv];
    if (state == mpq_pkg::ST_DECODE) begin
      if (req.cmd == mpq_pkg::CMD_ADD) begin
        push_en = !req_bad && !queued[req_slot];
      end else if (req.cmd == mpq_pkg::CMD_YIELD) begin
        push_slot = running_slot;
        push_lv   = running_level;
        push_en   = req.quantum_expired && running_valid && !queued[running_slot];
      end
      next_waddr = tail[push_lv];
      next_wdata = push_slot;
      prev_waddr = push_slot;
      prev_wdata = tail[push_lv];
      next_we    = push_en && nonempty[push_lv];
      prev_we    = push_en && nonempty[push_lv];
    end else if (state == mpq_pkg::ST_UNLINK) begin
      unlink_en  = is_sched || (lvl_rd == target_lv);
      next_waddr = prev_rd;
      next_wdata = next_rd;
      prev_waddr = next_rd;
      prev_wdata = prev_rd;
      next_we    = unlink_en && !is_head && !is_tail;
      prev_we    = unlink_en && !is_head && !is_tail;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= mpq_pkg::ST_IDLE;
      nonempty      <= '0;
      queued        <= '0;
      running_slot  <= '0;
      running_level <= '0;
      running_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (push_en) begin
        if (!nonempty[push_lv]) begin
          head[push_lv]     <= push_slot;
          nonempty[push_lv] <= 1'b1;
        end
        tail[push_lv]     <= push_slot;
        queued[push_slot] <= 1'b1;
      end
      if (unlink_en) begin
        if (is_head && is_tail) begin
          nonempty[target_lv] <= 1'b0;
        end else if (is_head) begin
          head[target_lv] <= next_rd;
        end else if (is_tail) begin
          tail[target_lv] <= prev_rd;
        end
        queued[target] <= 1'b0;
        if (is_sched) begin
          running_slot  <= target;
          running_level <= target_lv;
          running_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      mpq_pkg::ST_IDLE: begin
        req <= in_data;
      end
      mpq_pkg::ST_DECODE: begin
        target    <= req_slot;
        target_lv <= req_lv;
        is_sched  <= 1'b0;
        if (req.cmd == mpq_pkg::CMD_ADD || req.cmd == mpq_pkg::CMD_REMOVE) begin
          if (req_bad) begin
            status <= mpq_pkg::STATUS_IGNORED;
          end else if (req.cmd == mpq_pkg::CMD_ADD) begin
            status <= queued[req_slot] ? mpq_pkg::STATUS_IGNORED : mpq_pkg::STATUS_DONE;
          end else begin
            status <= queued[req_slot] ? mpq_pkg::STATUS_DONE : mpq_pkg::STATUS_IGNORED;
          end
        end
      end
      mpq_pkg::ST_PICK: begin
        target    <= head[pick_lv];
        target_lv <= pick_lv;
        is_sched  <= 1'b1;
        status    <= pick_found ? mpq_pkg::STATUS_DONE : mpq_pkg::STATUS_NONE;
      end
      mpq_pkg::ST_UNLINK: begin
        status <= unlink_en ? mpq_pkg::STATUS_DONE : mpq_pkg::STATUS_IGNORED;
      end
      default: begin
      end
    endcase
  end

  assign out_data.status         = status;
  assign out_data.current_thread = 6'(running_slot);
  assign out_data.current_valid  = running_valid;

endmodule

[test/multilevel_priority_ready_queue_tb.sv]
`timescale 1ns / 100ps

module multilevel_priority_ready_queue_tb;

  localparam int LEVELS = 31;
  localparam int SLOTS = 64;
  localparam int RANDOM_ITEMS = 650;
  localparam int CYCLE_LIMIT = 50000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  mpq_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  mpq_pkg::out_t out_data;

  multilevel_priority_ready_queue DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Scheduler state mirrored in the testbench.
  logic [5:0] q_head [LEVELS];
  logic [5:0] q_tail [LEVELS];
  logic [LEVELS-1:0] q_busy;
  logic [5:0] link_next [SLOTS];
  logic [5:0] link_prev [SLOTS];
  logic slot_in_queue [SLOTS];
  logic [4:0] slot_lvl [SLOTS];
  logic [5:0] run_slot;
  logic [4:0] run_lvl;
  logic run_valid;

  mpq_pkg::out_t pending_results [$];
  int errors = 0;
  int cycles = 0;
  logic stall_go = 1'b0;
  logic hold_off = 1'b0;
  logic quiet_rx = 1'b0;
  logic quiet_tx = 1'b0;

  function automatic void enqueue_slot(input int s, input int lv);
    if (q_busy[lv]) begin
      link_next[q_tail[lv]] = 6'(s);
      link_prev[s] = q_tail[lv];
    end else begin
      q_head[lv] = 6'(s);
      q_busy[lv] = 1'b1;
    end
    q_tail[lv] = 6'(s);
    slot_in_queue[s] = 1'b1;
    slot_lvl[s] = 5'(lv);
  endfunction

  function automatic void dequeue_slot(input int s);
    int lv;
    int p;
    int n;
    lv = int'(slot_lvl[s]);
    p = int'(link_prev[s]);
    n = int'(link_next[s]);
    if (int'(q_head[lv]) == s && int'(q_tail[lv]) == s) q_busy[lv] = 1'b0;
    else if (int'(q_head[lv]) == s) q_head[lv] = 6'(n);
    else if (int'(q_tail[lv]) == s) q_tail[lv] = 6'(p);
    else begin
      link_next[p] = 6'(n);
      link_prev[n] = 6'(p);
    end
    slot_in_queue[s] = 1'b0;
  endfunction

  function automatic mpq_pkg::out_t schedule_result(input mpq_pkg::in_t it);
    mpq_pkg::out_t r;
    int s;
    int p;
    r.status = mpq_pkg::STATUS_DONE;
    s = int'(it.thread_id);
    p = int'(it.priority_req);
    if (it.cmd == mpq_pkg::CMD_ADD || it.cmd == mpq_pkg::CMD_REMOVE) begin
      if (p == 0 || p > LEVELS) r.status = mpq_pkg::STATUS_IGNORED;
      else if (it.cmd == mpq_pkg::CMD_ADD) begin
        if (slot_in_queue[s]) r.status = mpq_pkg::STATUS_IGNORED;
        else enqueue_slot(s, p - 1);
      end else begin
        if (!slot_in_queue[s] || int'(slot_lvl[s]) != p - 1) r.status = mpq_pkg::STATUS_IGNORED;
        else dequeue_slot(s);
      end
    end else begin
      if (it.cmd == mpq_pkg::CMD_YIELD && it.quantum_expired && run_valid &&
          int'(run_lvl) < LEVELS && !slot_in_queue[run_slot])
        enqueue_slot(int'(run_slot), int'(run_lvl));
      r.status = mpq_pkg::STATUS_NONE;
      for (int lv = 0; lv < LEVELS; lv++) begin
        if (q_busy[lv] && r.status == mpq_pkg::STATUS_NONE) begin
          run_slot = q_head[lv];
          dequeue_slot(int'(run_slot));
          run_lvl = 5'(lv);
          run_valid = 1'b1;
          r.status = mpq_pkg::STATUS_DONE;
        end
      end
    end
    r.current_thread = run_slot;
    r.current_valid = run_valid;
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL multilevel_priority_ready_queue");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst || hold_off) out_ready <= 1'b0;
    else if (quiet_rx) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(99) >= 10);
  end

  always @(posedge clk) begin
    mpq_pkg::out_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected transaction status=%0d", out_data.status);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_data.status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, out_data.status);
          errors++;
        end
        if (out_data.current_thread !== e.current_thread) begin
          $error("current_thread expected %0d actual %0d", e.current_thread,
                 out_data.current_thread);
          errors++;
        end
        if (out_data.current_valid !== e.current_valid) begin
          $error("current_valid expected %0d actual %0d", e.current_valid,
                 out_data.current_valid);
          errors++;
        end
      end
    end
  end

  // Rows with a fixed expectation carry has_fixed; the rest use the predictor.
  typedef struct {
    mpq_pkg::in_t item;
    bit has_fixed;
    mpq_pkg::out_t fixed;
  } row_t;

  row_t rows [$];

  function automatic row_t mk(input mpq_pkg::cmd_t c, input int id, input int pr, input int q,
                              input int fx, input mpq_pkg::status_t st, input int cur,
                              input int cv);
    row_t r;
    r.item.cmd = c;
    r.item.thread_id = 6'(id);
    r.item.priority_req = 5'(pr);
    r.item.quantum_expired = 1'(q);
    r.has_fixed = 1'(fx);
    r.fixed.status = st;
    r.fixed.current_thread = 6'(cur);
    r.fixed.current_valid = 1'(cv);
    return r;
  endfunction

  task automatic send_item(input mpq_pkg::in_t it, input bit fx, input mpq_pkg::out_t fixed_res);
    mpq_pkg::out_t r;
    r = schedule_result(it);
    pending_results.push_back(fx ? fixed_res : r);
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (quiet_tx || $urandom_range(99) >= 10) return;
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 4)) @(posedge clk);
  endtask

  function automatic mpq_pkg::in_t random_item(input int pool);
    mpq_pkg::in_t it;
    int k;
    k = $urandom_range(99);
    it.thread_id = 6'($urandom_range(pool - 1));
    it.priority_req = (k < 5) ? 5'($urandom_range(31)) : 5'($urandom_range(1, 4));
    it.quantum_expired = 1'($urandom_range(1));
    if (k < 40) it.cmd = mpq_pkg::CMD_ADD;
    else if (k < 60) it.cmd = mpq_pkg::CMD_REMOVE;
    else if (k < 80) it.cmd = mpq_pkg::CMD_SCHEDULE;
    else it.cmd = mpq_pkg::CMD_YIELD;
    if (it.cmd == mpq_pkg::CMD_REMOVE && slot_in_queue[it.thread_id] && $urandom_range(3) != 0)
      it.priority_req = slot_lvl[it.thread_id] + 5'd1;
    return it;
  endfunction

  initial begin
    mpq_pkg::out_t none;
    mpq_pkg::in_t it;
    none = '0;
    q_busy = '0;
    run_slot = '0;
    run_lvl = '0;
    run_valid = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_in_queue[i] = 1'b0;
      slot_lvl[i] = '0;
    end
    rows.push_back(mk(mpq_pkg::CMD_SCHEDULE, 0, 0, 0, 1, mpq_pkg::STATUS_NONE, 0, 0));
    rows.push_back(mk(mpq_pkg::CMD_YIELD, 63, 31, 1, 1, mpq_pkg::STATUS_NONE, 0, 0));
    rows.push_back(mk(mpq_pkg::CMD_REMOVE, 5, 3, 0, 1, mpq_pkg::STATUS_IGNORED, 0, 0));
    rows.push_back(mk(mpq_pkg::CMD_ADD, 7, 0, 0, 1, mpq_pkg::STATUS_IGNORED, 0, 0));
    rows.push_back(mk(mpq_pkg::CMD_ADD, 0, 31, 0, 1, mpq_pkg::STATUS_DONE, 0, 0));
    rows.push_back(mk(mpq_pkg::CMD_ADD, 63, 1, 1, 1, mpq_pkg::STATUS_DONE, 0, 0));
    rows.push_back(mk(mpq_pkg::CMD_ADD, 63, 2, 0, 1, mpq_pkg::STATUS_IGNORED, 0, 0));
    rows.push_back(mk(mpq_pkg::CMD_ADD, 42, 1, 0, 0, mpq_pkg::STATUS_DONE, 0, 0));
    rows.push_back(mk(mpq_pkg::CMD_ADD, 21, 1, 0, 0, mpq_pkg::STATUS_DONE, 0, 0));
    rows.push_back(mk(mpq_pkg::CMD_REMOVE, 42, 2, 0, 1, mpq_pkg::STATUS_IGNORED, 0, 0));
    rows.push_back(mk(mpq_pkg::CMD_REMOVE, 42, 1, 0, 0, mpq_pkg::STATUS_DONE, 0, 0));
    rows.push_back(mk(mpq_pkg::CMD_SCHEDULE, 0, 0, 0, 1, mpq_pkg::STATUS_DONE, 63, 1));
    rows.push_back(mk(mpq_pkg::CMD_REMOVE, 63, 1, 0, 1, mpq_pkg::STATUS_IGNORED, 63, 1));
    rows.push_back(mk(mpq_pkg::CMD_YIELD, 0, 0, 1, 0, mpq_pkg::STATUS_DONE, 0, 0));
    rows.push_back(mk(mpq_pkg::CMD_YIELD, 0, 0, 0, 0, mpq_pkg::STATUS_DONE, 0, 0));
    rows.push_back(mk(mpq_pkg::CMD_ADD, 9, 31, 0, 0, mpq_pkg::STATUS_DONE, 0, 0));
    rows.push_back(mk(mpq_pkg::CMD_YIELD, 0, 0, 1, 0, mpq_pkg::STATUS_DONE, 0, 0));
    rows.push_back(mk(mpq_pkg::CMD_YIELD, 0, 0, 1, 0, mpq_pkg::STATUS_DONE, 0, 0));
    rows.push_back(mk(mpq_pkg::CMD_ADD, 30, 31, 0, 0, mpq_pkg::STATUS_DONE, 0, 0));
    rows.push_back(mk(mpq_pkg::CMD_REMOVE, 30, 31, 0, 0, mpq_pkg::STATUS_DONE, 0, 0));
    rows.push_back(mk(mpq_pkg::CMD_SCHEDULE, 0, 0, 0, 0, mpq_pkg::STATUS_DONE, 0, 0));
    rows.push_back(mk(mpq_pkg::CMD_SCHEDULE, 0, 0, 0, 0, mpq_pkg::STATUS_DONE, 0, 0));
    rows.push_back(mk(mpq_pkg::CMD_SCHEDULE, 0, 0, 0, 0, mpq_pkg::STATUS_DONE, 0, 0));

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    quiet_rx <= 1'b1;
    quiet_tx <= 1'b1;
    foreach (rows[i]) send_item(rows[i].item, rows[i].has_fixed, rows[i].fixed);
    quiet_rx <= 1'b0;
    quiet_tx <= 1'b0;

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 150) begin
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      if (n == 200) stall_go <= 1'b1;
      if (n == 300) begin
        quiet_rx <= 1'b1;
        quiet_tx <= 1'b1;
      end
      if (n == 400) begin
        quiet_rx <= 1'b0;
        quiet_tx <= 1'b0;
      end
      it = random_item((n < 300) ? 8 : 64);
      send_item(it, 1'b0, none);
    end
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("PASS multilevel_priority_ready_queue");
    else $display("FAIL multilevel_priority_ready_queue");
    $finish;
  end

  // Long receiver stall while the sender keeps offering.
  initial begin
    wait (stall_go);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

endmodule
